// File: src/worker_watchdog_restart_limiter_defines.svh
// ----------------------------------------------------------------------------
// Worker watchdog restart limiter assertion macros
// Shared assertion macros for the worker watchdog restart limiter. They are
// empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WORKER_WATCHDOG_RESTART_LIMITER_DEFINES_SVH
`define WORKER_WATCHDOG_RESTART_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
`define WWRL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wwrl: implication check failed");
`define WWRL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wwrl: next-cycle check failed");
`else
`define WWRL_ASSERT_IMPL(name, ante, cons)
`define WWRL_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: src/wwrl_pkg.sv
// ----------------------------------------------------------------------------
// Worker watchdog restart limiter package
// Sizes, event and action codes, register indexes, the sequencer states and
// the structs that pass between the modules of the block.
// ----------------------------------------------------------------------------
package wwrl_pkg;

  localparam int RESTART_SLOTS = 16;
  localparam int SLOT_W = (RESTART_SLOTS > 1) ? $clog2(RESTART_SLOTS) : 1;
  localparam int FILL_W = $clog2(RESTART_SLOTS + 1);
  localparam int ADDR_W = 4;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_BEAT     = 3'd1;
  localparam logic [2:0] KIND_TICK     = 3'd2;
  localparam logic [2:0] KIND_EXIT     = 3'd3;
  localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SPAWN = 2'd1;
  localparam logic [1:0] ACT_KILL  = 2'd2;
  localparam logic [1:0] ACT_TERM  = 2'd3;

  localparam logic [1:0] REG_RESTART_LIMIT     = 2'd0;
  localparam logic [1:0] REG_RESTART_WINDOW    = 2'd1;
  localparam logic [1:0] REG_HEARTBEAT_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_SHUTDOWN_TIMEOUT  = 2'd3;

  localparam logic [4:0]  RST_RESTART_LIMIT     = 5'd5;
  localparam logic [21:0] RST_RESTART_WINDOW    = 22'd10000;
  localparam logic [19:0] RST_HEARTBEAT_TIMEOUT = 20'd6000;
  localparam logic [18:0] RST_SHUTDOWN_TIMEOUT  = 19'd5000;

  typedef enum logic [1:0] {
    PH_DEAD     = 2'd0,
    PH_STARTING = 2'd1,
    PH_RUNNING  = 2'd2,
    PH_STOPPING = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TK_DL,
    ST_TK_WD,
    ST_EX_WR,
    ST_EX_RD,
    ST_EX_CMP,
    ST_EX_END,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [4:0]  restart_limit;
    logic [21:0] restart_window;
    logic [19:0] heartbeat_timeout;
    logic [18:0] shutdown_timeout;
  } cfg_t;

  typedef struct packed {
    logic gt;
    logic ge;
  } cmp_res_t;

endpackage

// File: src/wwrl_cfg.sv
// ----------------------------------------------------------------------------
// Worker watchdog restart limiter configuration registers
// APB register file for the restart limit, the restart window and the two
// timeouts, with read back.
// ----------------------------------------------------------------------------
module wwrl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wwrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output wwrl_pkg::cfg_t              cfg
);
  import wwrl_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.restart_limit     <= RST_RESTART_LIMIT;
      cfg.restart_window    <= RST_RESTART_WINDOW;
      cfg.heartbeat_timeout <= RST_HEARTBEAT_TIMEOUT;
      cfg.shutdown_timeout  <= RST_SHUTDOWN_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RESTART_LIMIT:     cfg.restart_limit     <= pwdata[4:0];
        REG_RESTART_WINDOW:    cfg.restart_window    <= pwdata[21:0];
        REG_HEARTBEAT_TIMEOUT: cfg.heartbeat_timeout <= pwdata[19:0];
        REG_SHUTDOWN_TIMEOUT:  cfg.shutdown_timeout  <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RESTART_LIMIT:     prdata = 32'(cfg.restart_limit);
      REG_RESTART_WINDOW:    prdata = 32'(cfg.restart_window);
      REG_HEARTBEAT_TIMEOUT: prdata = 32'(cfg.heartbeat_timeout);
      REG_SHUTDOWN_TIMEOUT:  prdata = 32'(cfg.shutdown_timeout);
      default:               prdata = '0;
    endcase
  end

endmodule

// File: src/wwrl_cmp.sv
// ----------------------------------------------------------------------------
// Worker watchdog restart limiter elapsed-time comparator
// Shared unit: takes the elapsed time now minus base modulo 2^32 and
// compares it against a limit.
// ----------------------------------------------------------------------------
module wwrl_cmp (
  input  logic [31:0]         now_val,
  input  logic [31:0]         base,
  input  logic [31:0]         lim,
  output wwrl_pkg::cmp_res_t  res
);
  import wwrl_pkg::*;

  logic [31:0] elapsed;

  assign elapsed = now_val - base;
  assign res.gt  = elapsed > lim;
  assign res.ge  = elapsed >= lim;

endmodule

// File: src/wwrl_ring.sv
// ----------------------------------------------------------------------------
// Worker watchdog restart limiter restart ring
// Memory of recent restart times, one write port and one read port with
// registered read data. Its contents are not cleared at reset.
// ----------------------------------------------------------------------------
module wwrl_ring (
  input  logic                        clk,
  input  logic                        we,
  input  logic [wwrl_pkg::SLOT_W-1:0] waddr,
  input  logic [31:0]                 wdata,
  input  logic [wwrl_pkg::SLOT_W-1:0] raddr,
  output logic [31:0]                 rdata
);
  import wwrl_pkg::*;

  logic [31:0] mem [RESTART_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/worker_watchdog_restart_limiter.sv
// ----------------------------------------------------------------------------
// Worker watchdog restart limiter
// A tick before supervision ends runs the deadline then watchdog check; a
// counted exit writes the ring, then scans n (1 to 16) entries one per cycle;
// other events skip to the result beat. The next event is taken the cycle after
// the result beat; results cannot stall. Synchronous reset restores register
// defaults and clears all control state; the ring is not cleared.
// ----------------------------------------------------------------------------
`include "worker_watchdog_restart_limiter_defines.svh"

module worker_watchdog_restart_limiter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  kind,
  input  logic [31:0]                 now_ms,
  output logic                        result_strobe,
  output logic [1:0]                  action,
  output logic [1:0]                  worker_state,
  output logic                        gave_up,
  output logic                        finished,
  output logic                        exit_status,
  output logic [4:0]                  recent_restarts,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wwrl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wwrl_pkg::*;

  cfg_t             cfg;
  cmp_res_t         res;
  state_t           state;
  state_t           state_next;

  logic [2:0]        ev_kind;
  logic [31:0]       ev_now;
  logic [1:0]        action_r;
  logic [4:0]        recent_r;
  phase_t            phase;
  logic              alive;
  logic              watch_armed;
  logic [31:0]       last_beat;
  logic              stopping_flag;
  logic              deadline_armed;
  logic [31:0]       deadline_start;
  logic              gave_up_flag;
  logic              exit_flag;
  logic              done_flag;
  logic [SLOT_W-1:0] ring_head;
  logic [FILL_W-1:0] ring_fill;
  logic [SLOT_W-1:0] rp;
  logic [FILL_W-1:0] cnt;
  logic [FILL_W-1:0] scan_i;

  logic              ring_we;
  logic [31:0]       ring_rdata;
  logic [31:0]       cmp_base;
  logic [31:0]       cmp_lim;
  logic [SLOT_W-1:0] rp_dec;
  logic [SLOT_W-1:0] head_inc;

  wwrl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wwrl_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_head),
    .wdata (ev_now),
    .raddr (rp),
    .rdata (ring_rdata)
  );

  wwrl_cmp u_cmp (
    .now_val (ev_now),
    .base    (cmp_base),
    .lim     (cmp_lim),
    .res     (res)
  );

  assign rp_dec   = (rp == '0) ? SLOT_W'(RESTART_SLOTS - 1) : rp - SLOT_W'(1);
  assign head_inc = (ring_head == SLOT_W'(RESTART_SLOTS - 1)) ? '0
                                                              : ring_head + SLOT_W'(1);

  always_comb begin
    if (state == ST_TK_WD) begin
      cmp_base = last_beat;
      cmp_lim  = 32'(cfg.heartbeat_timeout);
    end else if (state == ST_EX_CMP) begin
      cmp_base = ring_rdata;
      cmp_lim  = 32'(cfg.restart_window);
    end else begin
      cmp_base = deadline_start;
      cmp_lim  = 32'(cfg.shutdown_timeout);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ring_we       = 1'b0;
    busy          = (state != ST_IDLE);
    result_strobe = (state == ST_OUT);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (done_flag) begin
          state_next = ST_OUT;
        end else if (ev_kind == KIND_TICK) begin
          state_next = ST_TK_DL;
        end else if (ev_kind == KIND_EXIT && alive && !stopping_flag) begin
          state_next = ST_EX_WR;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_TK_DL:  state_next = ST_TK_WD;
      ST_TK_WD:  state_next = ST_OUT;
      ST_EX_WR: begin
        ring_we    = 1'b1;
        state_next = ST_EX_RD;
      end
      ST_EX_RD:  state_next = ST_EX_CMP;
      ST_EX_CMP: begin
        if (!res.gt && ((scan_i + FILL_W'(1)) < ring_fill)) begin
          state_next = ST_EX_CMP;
        end else begin
          state_next = ST_EX_END;
        end
      end
      ST_EX_END: state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      action_r       <= ACT_NONE;
      recent_r       <= '0;
      phase          <= PH_DEAD;
      alive          <= 1'b0;
      watch_armed    <= 1'b0;
      last_beat      <= '0;
      stopping_flag  <= 1'b0;
      deadline_armed <= 1'b0;
      deadline_start <= '0;
      gave_up_flag   <= 1'b0;
      exit_flag      <= 1'b0;
      done_flag      <= 1'b0;
      ring_head      <= '0;
      ring_fill      <= '0;
      rp             <= '0;
      cnt            <= '0;
      scan_i         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            ev_kind  <= kind;
            ev_now   <= now_ms;
            action_r <= ACT_NONE;
            recent_r <= '0;
          end
        end
        ST_DECODE: begin
          if (!done_flag) begin
            unique case (ev_kind)
              KIND_START: begin
                if (!alive && !stopping_flag) begin
                  alive       <= 1'b1;
                  phase       <= PH_STARTING;
                  watch_armed <= 1'b0;
                  last_beat   <= ev_now;
                  action_r    <= ACT_SPAWN;
                end
              end
              KIND_BEAT: begin
                if (alive) begin
                  last_beat   <= ev_now;
                  watch_armed <= 1'b1;
                  if (phase == PH_STARTING) begin
                    phase <= PH_RUNNING;
                  end
                end
              end
              KIND_EXIT: begin
                if (alive) begin
                  alive       <= 1'b0;
                  phase       <= PH_DEAD;
                  watch_armed <= 1'b0;
                  if (stopping_flag) begin
                    deadline_armed <= 1'b0;
                    done_flag      <= 1'b1;
                  end
                end
              end
              KIND_SHUTDOWN: begin
                if (!stopping_flag) begin
                  stopping_flag <= 1'b1;
                  if (alive) begin
                    phase          <= PH_STOPPING;
                    deadline_armed <= 1'b1;
                    deadline_start <= ev_now;
                    action_r       <= ACT_TERM;
                  end else begin
                    done_flag <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_TK_DL: begin
          if (deadline_armed && res.ge) begin
            deadline_armed <= 1'b0;
            if (alive) begin
              action_r  <= ACT_KILL;
              exit_flag <= 1'b1;
            end
          end
        end
        ST_TK_WD: begin
          if (watch_armed && alive && res.gt) begin
            watch_armed <= 1'b0;
            action_r    <= ACT_KILL;
          end
        end
        ST_EX_WR: begin
          rp        <= ring_head;
          ring_head <= head_inc;
          if (ring_fill < FILL_W'(RESTART_SLOTS)) begin
            ring_fill <= ring_fill + FILL_W'(1);
          end
          cnt    <= '0;
          scan_i <= '0;
        end
        ST_EX_RD: begin
          rp <= rp_dec;
        end
        ST_EX_CMP: begin
          rp <= rp_dec;
          if (!res.gt) begin
            cnt    <= cnt + FILL_W'(1);
            scan_i <= scan_i + FILL_W'(1);
          end
        end
        ST_EX_END: begin
          recent_r <= (32'(cnt) > 32'd31) ? 5'd31 : 5'(cnt);
          if (32'(cnt) >= 32'(cfg.restart_limit)) begin
            gave_up_flag <= 1'b1;
            done_flag    <= 1'b1;
            exit_flag    <= 1'b1;
          end else begin
            alive       <= 1'b1;
            phase       <= PH_STARTING;
            watch_armed <= 1'b0;
            last_beat   <= ev_now;
            action_r    <= ACT_SPAWN;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign action          = action_r;
  assign worker_state    = phase;
  assign gave_up         = gave_up_flag;
  assign finished        = done_flag;
  assign exit_status     = exit_flag;
  assign recent_restarts = recent_r;

  `WWRL_ASSERT_NEXT(a_beat_then_ready, result_strobe, !busy)
  `WWRL_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy && !result_strobe)
  `WWRL_ASSERT_NEXT(a_done_sticky, done_flag, done_flag)
  `WWRL_ASSERT_IMPL(a_gave_up_done, gave_up_flag, done_flag && exit_flag)
  `WWRL_ASSERT_IMPL(a_count_in_fill, state == ST_EX_CMP || state == ST_EX_END, cnt <= ring_fill)

endmodule
